// ----- sv/prps_pkg.sv -----
// ---------------------------------------------------------------------------
// Point rotate, project and shade: shared package
// Field widths, word layouts, register indexes and fixed-point constants used
// by every stage of the point pipeline.
// ---------------------------------------------------------------------------
package prps_pkg;

    localparam int COORD_W           = 16;
    localparam int COORD_FRAC_BITS   = 13;
    localparam int SCREEN_COORD_BITS = 12;
    localparam int TRIG_W            = 16;
    localparam int TRIG_FRAC         = 14;
    localparam int ROT_SHIFT         = 2 * TRIG_FRAC;
    localparam int ZOOM_W            = 14;
    localparam int CFG_W             = 48;
    localparam int CFG_IDX_W         = 3;

    // Datapath widths.
    localparam int PROD_W  = 2 * COORD_W;
    localparam int PROD2_W = PROD_W + TRIG_W;
    localparam int SUM_W   = PROD2_W + 2;
    localparam int POS_W   = 24;
    localparam int ACOEF_W = SCREEN_COORD_BITS + 8;
    localparam int NUM_W   = 64;
    localparam int DEN_W   = POS_W + 18;
    localparam int QUO_W   = SCREEN_COORD_BITS + 1;

    localparam logic signed [SUM_W-1:0] ROT_HALF = SUM_W'(1) << (ROT_SHIFT - 1);
    localparam logic signed [POS_W-1:0] DEPTH_OFFSET = POS_W'(3) << COORD_FRAC_BITS;
    // Smallest divisor d with 1000 * d >= 1.0 in coordinate units.
    localparam logic signed [POS_W-1:0] DENOM_MIN =
        POS_W'(((1 << COORD_FRAC_BITS) + 999) / 1000);

    // Colour shading: n / 1275 as (n * SHADE_RECIP) >> SHADE_SHIFT, exact for n < 2^19.
    localparam logic [19:0] SHADE_RECIP = 20'd842151;
    localparam int          SHADE_SHIFT = 30;
    localparam logic [7:0]  FULL_INTEN  = 8'd142;
    localparam logic [7:0]  DARK_FLOOR  = 8'd60;

    // Register reset values.
    localparam logic [TRIG_W-1:0] RST_COS_PITCH = 16'd15091;
    localparam logic [TRIG_W-1:0] RST_SIN_PITCH = 16'd6380;
    localparam logic [TRIG_W-1:0] RST_COS_YAW   = 16'd13522;
    localparam logic [TRIG_W-1:0] RST_SIN_YAW   = 16'd9251;
    localparam logic [CFG_W-1:0]  RST_CAMERA    = 48'd0;
    localparam logic [ZOOM_W-1:0] RST_ZOOM      = 14'd4096;
    localparam logic [CFG_W-1:0]  RST_VIEWPORT  = 48'd32996086251520;
    localparam logic [31:0]       RST_PAN       = 32'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COS_PITCH = 3'd0,
        CFG_SIN_PITCH = 3'd1,
        CFG_COS_YAW   = 3'd2,
        CFG_SIN_YAW   = 3'd3,
        CFG_CAMERA    = 3'd4,
        CFG_ZOOM      = 3'd5,
        CFG_VIEWPORT  = 3'd6,
        CFG_PAN       = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_pitch;
        logic signed [TRIG_W-1:0]  sin_pitch;
        logic signed [TRIG_W-1:0]  cos_yaw;
        logic signed [TRIG_W-1:0]  sin_yaw;
        logic signed [COORD_W-1:0] cam_x;
        logic signed [COORD_W-1:0] cam_y;
        logic signed [COORD_W-1:0] cam_z;
        logic [ZOOM_W-1:0]         zoom;
        logic [SCREEN_COORD_BITS-1:0] org_x;
        logic [SCREEN_COORD_BITS-1:0] org_y;
        logic [SCREEN_COORD_BITS-1:0] width;
        logic [SCREEN_COORD_BITS-1:0] height;
        logic signed [15:0]        pan_x;
        logic signed [15:0]        pan_y;
    } t_cfg;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic [7:0]                intensity;
        logic [7:0]                red_in;
        logic [7:0]                green_in;
        logic [7:0]                blue_in;
    } t_in_word;

    typedef struct packed {
        logic [SCREEN_COORD_BITS-1:0] screen_x;
        logic [SCREEN_COORD_BITS-1:0] screen_y;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
    } t_out_word;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_color;

    // Camera-relative point with its perspective divisor.
    typedef struct packed {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] den;
        t_color                  color;
    } t_point;

    // Screen coordinates as numerator over a common positive denominator.
    typedef struct packed {
        logic signed [NUM_W-1:0] num_x;
        logic signed [NUM_W-1:0] num_y;
        logic [DEN_W-1:0]        den2;
        t_color                  color;
    } t_frac;

endpackage

// ----- sv/prps_rotate.sv -----
// ---------------------------------------------------------------------------
// Point rotate, project and shade: rotation and shading stages
// Four register stages: trig products, second products, rounded sums, then
// camera offset and divisor test. The colour is shaded alongside.
// ---------------------------------------------------------------------------
module prps_rotate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  prps_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    output logic               o_ready,
    input  prps_pkg::t_in_word i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output prps_pkg::t_point   o_data
);

    typedef enum logic [1:0] {
        DOM_RED,
        DOM_GREEN,
        DOM_BLUE
    } t_dom;

    function automatic logic [7:0] shade_div(input logic [19:0] n);
        logic [39:0] p;
        p = 40'(n) * 40'(prps_pkg::SHADE_RECIP);
        return p[prps_pkg::SHADE_SHIFT +: 8];
    endfunction

    logic [3:0] en;
    logic r_v1, r_v2, r_v3, r_v4;

    // Stage 1.
    logic signed [prps_pkg::PROD_W-1:0] r1_a, r1_b, r1_c, r1_d, r1_e, r1_f;
    logic [19:0] r1_n_red, r1_n_green, r1_n_blue;
    logic        r1_full;
    prps_pkg::t_color r1_color;
    t_dom        r1_dom;

    // Stage 2.
    logic signed [prps_pkg::PROD_W-1:0]  r2_a, r2_b, r2_c, r2_d;
    logic signed [prps_pkg::PROD2_W-1:0] r2_sy_e, r2_sy_f, r2_cy_e, r2_cy_f;
    prps_pkg::t_color r2_color;
    t_dom             r2_dom;

    // Stage 3.
    logic signed [prps_pkg::POS_W-1:0] r3_rx, r3_ry, r3_rz;
    prps_pkg::t_color r3_color;

    // Stage 4.
    logic signed [prps_pkg::POS_W-1:0] r4_px, r4_py, r4_den;
    prps_pkg::t_color r4_color;

    logic [19:0] n_red, n_green, n_blue;
    t_dom        n_dom;
    logic signed [prps_pkg::SUM_W-1:0] n_rx_sum, n_ry_sum, n_rz_sum;
    prps_pkg::t_color n_color3;
    logic [7:0]  n_max;
    logic signed [prps_pkg::POS_W-1:0] n_den;

    assign en[3]   = !r_v4 || i_ready;
    assign en[2]   = !r_v3 || en[3];
    assign en[1]   = !r_v2 || en[2];
    assign en[0]   = !r_v1 || en[1];
    assign o_ready = en[0];

    always_comb begin
        n_red   = 20'(i_data.red_in) * 20'(i_data.intensity) * 20'd9;
        n_green = 20'(i_data.green_in) * 20'(i_data.intensity) * 20'd9;
        n_blue  = 20'(i_data.blue_in) * 20'(i_data.intensity) * 20'd9;
        if (i_data.blue_in >= i_data.red_in && i_data.blue_in >= i_data.green_in) begin
            n_dom = DOM_BLUE;
        end else if (i_data.red_in >= i_data.green_in) begin
            n_dom = DOM_RED;
        end else begin
            n_dom = DOM_GREEN;
        end
    end

    always_comb begin
        n_rx_sum = (prps_pkg::SUM_W'(r2_a) <<< prps_pkg::TRIG_FRAC)
                 + prps_pkg::SUM_W'(r2_sy_e) + prps_pkg::SUM_W'(r2_sy_f)
                 + prps_pkg::ROT_HALF;
        n_ry_sum = ((prps_pkg::SUM_W'(r2_c) - prps_pkg::SUM_W'(r2_d)) <<< prps_pkg::TRIG_FRAC)
                 + prps_pkg::ROT_HALF;
        n_rz_sum = prps_pkg::SUM_W'(r2_cy_e) + prps_pkg::SUM_W'(r2_cy_f)
                 - (prps_pkg::SUM_W'(r2_b) <<< prps_pkg::TRIG_FRAC)
                 + prps_pkg::ROT_HALF;

        // A pixel that would be too dark has its originally dominant channel lifted.
        n_color3 = r2_color;
        n_max = (r2_color.red > r2_color.green) ? r2_color.red : r2_color.green;
        if (r2_color.blue > n_max) begin
            n_max = r2_color.blue;
        end
        if (n_max < prps_pkg::DARK_FLOOR) begin
            case (r2_dom)
                DOM_BLUE:  n_color3.blue  = prps_pkg::DARK_FLOOR;
                DOM_RED:   n_color3.red   = prps_pkg::DARK_FLOOR;
                DOM_GREEN: n_color3.green = prps_pkg::DARK_FLOOR;
                default:   n_color3       = r2_color;
            endcase
        end

        n_den = r3_rz - prps_pkg::POS_W'(i_cfg.cam_z) + prps_pkg::DEPTH_OFFSET;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en[0]) r_v1 <= i_valid;
            if (en[1]) r_v2 <= r_v1;
            if (en[2]) r_v3 <= r_v2;
            if (en[3]) r_v4 <= r_v3 && (n_den >= prps_pkg::DENOM_MIN);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_a       <= i_cfg.cos_yaw * i_data.point_x;
            r1_b       <= i_cfg.sin_yaw * i_data.point_x;
            r1_c       <= i_cfg.cos_pitch * i_data.point_y;
            r1_d       <= i_cfg.sin_pitch * i_data.point_z;
            r1_e       <= i_cfg.sin_pitch * i_data.point_y;
            r1_f       <= i_cfg.cos_pitch * i_data.point_z;
            r1_n_red   <= n_red;
            r1_n_green <= n_green;
            r1_n_blue  <= n_blue;
            r1_full    <= i_data.intensity >= prps_pkg::FULL_INTEN;
            r1_color   <= '{red: i_data.red_in, green: i_data.green_in, blue: i_data.blue_in};
            r1_dom     <= n_dom;
        end
        if (en[1]) begin
            r2_a    <= r1_a;
            r2_b    <= r1_b;
            r2_c    <= r1_c;
            r2_d    <= r1_d;
            r2_sy_e <= i_cfg.sin_yaw * r1_e;
            r2_sy_f <= i_cfg.sin_yaw * r1_f;
            r2_cy_e <= i_cfg.cos_yaw * r1_e;
            r2_cy_f <= i_cfg.cos_yaw * r1_f;
            r2_dom  <= r1_dom;
            if (r1_full) begin
                r2_color <= r1_color;
            end else begin
                r2_color <= '{red:   shade_div(r1_n_red),
                              green: shade_div(r1_n_green),
                              blue:  shade_div(r1_n_blue)};
            end
        end
        if (en[2]) begin
            r3_rx    <= prps_pkg::POS_W'(n_rx_sum >>> prps_pkg::ROT_SHIFT);
            r3_ry    <= prps_pkg::POS_W'(n_ry_sum >>> prps_pkg::ROT_SHIFT);
            r3_rz    <= prps_pkg::POS_W'(n_rz_sum >>> prps_pkg::ROT_SHIFT);
            r3_color <= n_color3;
        end
        if (en[3]) begin
            r4_px    <= r3_rx - prps_pkg::POS_W'(i_cfg.cam_x);
            r4_py    <= r3_ry - prps_pkg::POS_W'(i_cfg.cam_y);
            r4_den   <= n_den;
            r4_color <= r3_color;
        end
    end

    assign o_valid = r_v4;
    assign o_data  = '{px: r4_px, py: r4_py, den: r4_den, color: r4_color};

endmodule

// ----- sv/prps_project.sv -----
// ---------------------------------------------------------------------------
// Point rotate, project and shade: projection stages
// Three register stages that form each screen coordinate as a numerator over
// the common denominator 2 * 81920 * divisor.
// ---------------------------------------------------------------------------
module prps_project (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  prps_pkg::t_cfg   i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  prps_pkg::t_point i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output prps_pkg::t_frac  o_data
);

    localparam int BASE_W = prps_pkg::POS_W + prps_pkg::ACOEF_W;
    localparam int TW_W   = prps_pkg::POS_W + prps_pkg::SCREEN_COORD_BITS + 1;
    localparam int Z18_W  = prps_pkg::ZOOM_W + 5;

    logic [2:0] en;
    logic r_v1, r_v2, r_v3;

    logic signed [BASE_W-1:0] r1_bx, r1_by;
    logic signed [TW_W-1:0]   r1_tx, r1_ty;
    logic signed [prps_pkg::POS_W-1:0] r1_den;
    prps_pkg::t_color r1_color;

    logic signed [prps_pkg::NUM_W-1:0] r2_bx, r2_by, r2_mx, r2_my;
    logic [prps_pkg::DEN_W-1:0] r2_den2;
    prps_pkg::t_color r2_color;

    logic signed [prps_pkg::NUM_W-1:0] r3_num_x, r3_num_y;
    logic [prps_pkg::DEN_W-1:0] r3_den2;
    prps_pkg::t_color r3_color;

    logic signed [prps_pkg::ACOEF_W-1:0] n_ax, n_ay;
    logic signed [prps_pkg::SCREEN_COORD_BITS:0] n_w;
    logic signed [Z18_W:0] n_z18;
    logic [prps_pkg::DEN_W-1:0] n_d;

    assign en[2]   = !r_v3 || i_ready;
    assign en[1]   = !r_v2 || en[2];
    assign en[0]   = !r_v1 || en[1];
    assign o_ready = en[0];

    always_comb begin
        // Twice the viewport centre plus twice the pan.
        n_ax = (prps_pkg::ACOEF_W'(i_cfg.org_x) <<< 1) + prps_pkg::ACOEF_W'(i_cfg.width)
             + (prps_pkg::ACOEF_W'(i_cfg.pan_x) <<< 1);
        n_ay = (prps_pkg::ACOEF_W'(i_cfg.org_y) <<< 1) + prps_pkg::ACOEF_W'(i_cfg.height)
             + (prps_pkg::ACOEF_W'(i_cfg.pan_y) <<< 1);
        n_w   = signed'({1'b0, i_cfg.width});
        n_z18 = signed'({1'b0, Z18_W'(i_cfg.zoom) * Z18_W'(18)});
        n_d   = prps_pkg::DEN_W'(unsigned'(r1_den));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en[0]) r_v1 <= i_valid;
            if (en[1]) r_v2 <= r_v1;
            if (en[2]) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r1_bx    <= i_data.den * n_ax;
            r1_by    <= i_data.den * n_ay;
            r1_tx    <= i_data.px * n_w;
            r1_ty    <= i_data.py * n_w;
            r1_den   <= i_data.den;
            r1_color <= i_data.color;
        end
        if (en[1]) begin
            // 81920 = 2^16 + 2^14.
            r2_bx    <= (prps_pkg::NUM_W'(r1_bx) <<< 16) + (prps_pkg::NUM_W'(r1_bx) <<< 14);
            r2_by    <= (prps_pkg::NUM_W'(r1_by) <<< 16) + (prps_pkg::NUM_W'(r1_by) <<< 14);
            r2_mx    <= prps_pkg::NUM_W'(r1_tx * n_z18);
            r2_my    <= prps_pkg::NUM_W'(r1_ty * n_z18);
            r2_den2  <= (n_d << 17) + (n_d << 15);
            r2_color <= r1_color;
        end
        if (en[2]) begin
            r3_num_x <= r2_bx + r2_mx;
            r3_num_y <= r2_by - r2_my;
            r3_den2  <= r2_den2;
            r3_color <= r2_color;
        end
    end

    assign o_valid = r_v3;
    assign o_data  = '{num_x: r3_num_x, num_y: r3_num_y, den2: r3_den2, color: r3_color};

endmodule

// ----- sv/prps_divide.sv -----
// ---------------------------------------------------------------------------
// Point rotate, project and shade: pipelined divider and viewport clip
// A magnitude and range stage, one restoring quotient bit per stage for both
// coordinates, and a final clip stage that holds the output word.
// ---------------------------------------------------------------------------
module prps_divide (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prps_pkg::t_cfg      i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  prps_pkg::t_frac     i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output prps_pkg::t_out_word o_data
);

    localparam int NQ = prps_pkg::QUO_W;
    localparam int NW = prps_pkg::NUM_W;
    localparam int SB = prps_pkg::SCREEN_COORD_BITS;

    logic [NQ+1:0] en;

    logic                       r_v     [0:NQ];
    logic [NW-1:0]              r_rem_x [0:NQ];
    logic [NW-1:0]              r_rem_y [0:NQ];
    logic [NQ-1:0]              r_q_x   [0:NQ];
    logic [NQ-1:0]              r_q_y   [0:NQ];
    logic [prps_pkg::DEN_W-1:0] r_den   [0:NQ];
    prps_pkg::t_color           r_color [0:NQ];

    logic                r_out_v;
    prps_pkg::t_out_word r_out;

    logic [NW-1:0] n_mag_x, n_mag_y, n_den_w, n_den_top;
    logic          n_keep, n_in_x, n_in_y;

    assign en[NQ+1] = !r_out_v || i_ready;
    assign o_ready  = en[0];

    genvar k;
    generate
        for (k = 0; k <= NQ; k++) begin : g_en
            assign en[k] = !r_v[k] || en[k+1];
        end
    endgenerate

    // Quotients of 2^QUO_W or more, and negative non-zero quotients, are off screen.
    always_comb begin
        n_mag_x   = i_data.num_x[NW-1] ? NW'(-i_data.num_x) : NW'(i_data.num_x);
        n_mag_y   = i_data.num_y[NW-1] ? NW'(-i_data.num_y) : NW'(i_data.num_y);
        n_den_w   = NW'(i_data.den2);
        n_den_top = n_den_w << NQ;
        n_keep    = (n_mag_x < n_den_top) && (n_mag_y < n_den_top)
                 && !(i_data.num_x[NW-1] && n_mag_x >= n_den_w)
                 && !(i_data.num_y[NW-1] && n_mag_y >= n_den_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (en[0]) begin
            r_v[0] <= i_valid && n_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem_x[0] <= n_mag_x;
            r_rem_y[0] <= n_mag_y;
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_den[0]   <= i_data.den2;
            r_color[0] <= i_data.color;
        end
    end

    generate
        for (k = 0; k < NQ; k++) begin : g_bit
            localparam int BIT = NQ - 1 - k;
            logic [NW-1:0] w_sub;
            logic          w_ge_x, w_ge_y;

            assign w_sub  = NW'(r_den[k]) << BIT;
            assign w_ge_x = r_rem_x[k] >= w_sub;
            assign w_ge_y = r_rem_y[k] >= w_sub;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k+1] <= 1'b0;
                end else if (en[k+1]) begin
                    r_v[k+1] <= r_v[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (en[k+1]) begin
                    r_rem_x[k+1] <= w_ge_x ? r_rem_x[k] - w_sub : r_rem_x[k];
                    r_rem_y[k+1] <= w_ge_y ? r_rem_y[k] - w_sub : r_rem_y[k];
                    r_q_x[k+1]   <= r_q_x[k] | (NQ'(w_ge_x) << BIT);
                    r_q_y[k+1]   <= r_q_y[k] | (NQ'(w_ge_y) << BIT);
                    r_den[k+1]   <= r_den[k];
                    r_color[k+1] <= r_color[k];
                end
            end
        end
    endgenerate

    always_comb begin
        n_in_x = (r_q_x[NQ] >= NQ'(i_cfg.org_x))
              && ((NQ+1)'(r_q_x[NQ]) < (NQ+1)'(i_cfg.org_x) + (NQ+1)'(i_cfg.width));
        n_in_y = (r_q_y[NQ] >= NQ'(i_cfg.org_y))
              && ((NQ+1)'(r_q_y[NQ]) < (NQ+1)'(i_cfg.org_y) + (NQ+1)'(i_cfg.height));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en[NQ+1]) begin
            r_out_v <= r_v[NQ] && n_in_x && n_in_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NQ+1]) begin
            r_out <= '{screen_x: r_q_x[NQ][SB-1:0],
                       screen_y: r_q_y[NQ][SB-1:0],
                       red:      r_color[NQ].red,
                       green:    r_color[NQ].green,
                       blue:     r_color[NQ].blue};
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

// ----- sv/point_rotate_project_shade_core.sv -----
// ---------------------------------------------------------------------------
// Point rotate, project and shade: top level
// Rotates a coloured point, subtracts the camera, projects it onto the
// viewport and shades its colour; off-screen or too-near points give no word.
// ---------------------------------------------------------------------------
//
//  Channel    Handshake              Payload
//  ---------  ---------------------  --------------------------------------
//  point in   i_valid / o_ready      i_data  (t_in_word)
//  pixel out  o_valid / i_ready      o_data  (t_out_word)
//  registers  i_cfg_we              i_cfg_idx, i_cfg_data (48 bits)
//
// One word is taken every clock unless every stage is full and the output is blocked.
// A pixel passes four rotation stages, three projection stages and fifteen
// stages of the bit-per-stage divider with its clip stage.
// Reset loads the register defaults and empties every stage.
// A stage holds only while full and the stage after it is blocked, so gaps and
// dropped points close up; input flows while a pixel waits until all stages fill.
// ---------------------------------------------------------------------------
module point_rotate_project_shade_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  prps_pkg::t_in_word                 i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output prps_pkg::t_out_word                o_data,
    input  logic                               i_cfg_we,
    input  logic [prps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [prps_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int SB = prps_pkg::SCREEN_COORD_BITS;

    logic [prps_pkg::TRIG_W-1:0] r_cos_pitch, r_sin_pitch, r_cos_yaw, r_sin_yaw;
    logic [prps_pkg::CFG_W-1:0]  r_camera, r_viewport;
    logic [prps_pkg::ZOOM_W-1:0] r_zoom;
    logic [31:0]                 r_pan;

    prps_pkg::t_cfg   cfg;
    logic             rot_valid, rot_ready, prj_valid, prj_ready;
    prps_pkg::t_point rot_data;
    prps_pkg::t_frac  prj_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos_pitch <= prps_pkg::RST_COS_PITCH;
            r_sin_pitch <= prps_pkg::RST_SIN_PITCH;
            r_cos_yaw   <= prps_pkg::RST_COS_YAW;
            r_sin_yaw   <= prps_pkg::RST_SIN_YAW;
            r_camera    <= prps_pkg::RST_CAMERA;
            r_zoom      <= prps_pkg::RST_ZOOM;
            r_viewport  <= prps_pkg::RST_VIEWPORT;
            r_pan       <= prps_pkg::RST_PAN;
        end else if (i_cfg_we) begin
            case (prps_pkg::t_cfg_idx'(i_cfg_idx))
                prps_pkg::CFG_COS_PITCH: r_cos_pitch <= i_cfg_data[prps_pkg::TRIG_W-1:0];
                prps_pkg::CFG_SIN_PITCH: r_sin_pitch <= i_cfg_data[prps_pkg::TRIG_W-1:0];
                prps_pkg::CFG_COS_YAW:   r_cos_yaw   <= i_cfg_data[prps_pkg::TRIG_W-1:0];
                prps_pkg::CFG_SIN_YAW:   r_sin_yaw   <= i_cfg_data[prps_pkg::TRIG_W-1:0];
                prps_pkg::CFG_CAMERA:    r_camera    <= i_cfg_data;
                prps_pkg::CFG_ZOOM:      r_zoom      <= i_cfg_data[prps_pkg::ZOOM_W-1:0];
                prps_pkg::CFG_VIEWPORT:  r_viewport  <= i_cfg_data;
                prps_pkg::CFG_PAN:       r_pan       <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.cos_pitch = signed'(r_cos_pitch);
        cfg.sin_pitch = signed'(r_sin_pitch);
        cfg.cos_yaw   = signed'(r_cos_yaw);
        cfg.sin_yaw   = signed'(r_sin_yaw);
        cfg.cam_x     = signed'(r_camera[15:0]);
        cfg.cam_y     = signed'(r_camera[31:16]);
        cfg.cam_z     = signed'(r_camera[47:32]);
        cfg.zoom      = r_zoom;
        cfg.org_x     = r_viewport[0*SB +: SB];
        cfg.org_y     = r_viewport[1*SB +: SB];
        cfg.width     = r_viewport[2*SB +: SB];
        cfg.height    = r_viewport[3*SB +: SB];
        cfg.pan_x     = signed'(r_pan[15:0]);
        cfg.pan_y     = signed'(r_pan[31:16]);
    end

    prps_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (rot_valid),
        .i_ready (rot_ready),
        .o_data  (rot_data)
    );

    prps_project u_project (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (rot_valid),
        .o_ready (rot_ready),
        .i_data  (rot_data),
        .o_valid (prj_valid),
        .i_ready (prj_ready),
        .o_data  (prj_data)
    );

    prps_divide u_divide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (prj_valid),
        .o_ready (prj_ready),
        .i_data  (prj_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
